/* design/assert_macros.svh */
// Assertion macros for the display scanner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define MSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define MSS_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* design/mss_pkg.sv */
// Package: types, constants and glyph table of the seven-segment scanner.
package mss_pkg;

    localparam int DIGITS    = 4;
    localparam int MSG_DEPTH = 32;

    localparam int DIG_IDX_W = $clog2(DIGITS);
    localparam int MSG_IDX_W = $clog2(MSG_DEPTH);
    localparam int CNT_W     = $clog2(MSG_DEPTH + 1);
    localparam int WIN_W     = CNT_W + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [7:0]  REFRESH_RESET = 8'd4;
    localparam logic [15:0] BRIGHT_RESET  = 16'hFFFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT  = 2'd1;

    // request codes
    localparam logic [3:0] REQ_TICK   = 4'd0;
    localparam logic [3:0] REQ_START  = 4'd1;
    localparam logic [3:0] REQ_CHAR   = 4'd2;
    localparam logic [3:0] REQ_RIGHT  = 4'd3;
    localparam logic [3:0] REQ_LEFT   = 4'd4;
    localparam logic [3:0] REQ_CLEAR  = 4'd5;
    localparam logic [3:0] REQ_ON     = 4'd6;
    localparam logic [3:0] REQ_OFF    = 4'd7;
    localparam logic [3:0] REQ_TOGGLE = 4'd8;
    localparam logic [3:0] REQ_BLINK  = 4'd9;
    localparam logic [3:0] REQ_DP     = 4'd10;

    // digit modes
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_ON    = 2'd1;
    localparam logic [1:0] MODE_BLINK = 2'd2;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [1:0]  digit;
        logic [7:0]  value;
        logic        point_on;
        logic [15:0] blink_reload;
    } item_t;

    typedef struct packed {
        logic [6:0] segments;
        logic       point;
        logic [1:0] select;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic emit;
    } status_t;

    localparam logic [6:0] GLYPHS [75] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F, 7'h00, 7'h00,
        7'h00, 7'h40, 7'h00, 7'h00, 7'h00, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3D,
        7'h76, 7'h30, 7'h1E, 7'h75, 7'h38, 7'h55, 7'h54, 7'h5C, 7'h73, 7'h67, 7'h50, 7'h6D,
        7'h78, 7'h3E, 7'h1C, 7'h1D, 7'h64, 7'h6E, 7'h5B, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3D, 7'h76, 7'h30, 7'h1E, 7'h75,
        7'h38, 7'h55, 7'h54, 7'h5C, 7'h73, 7'h67, 7'h50, 7'h6D, 7'h78, 7'h3E, 7'h1C, 7'h1D,
        7'h64, 7'h6E, 7'h5B
    };

    // ASCII '0'..'z' to glyph, anything else blank
    function automatic logic [6:0] decode_glyph(input logic [7:0] code);
        logic [7:0] offs;
        offs = code - 8'h30;
        if (code >= 8'h30 && code <= 8'h7A) begin
            return GLYPHS[offs[6:0]];
        end
        return 7'h00;
    endfunction

endpackage

/* design/mss_ctrl.sv */
// Controller: sequences item execution and result hand-off.
`include "assert_macros.svh"

module mss_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    output logic             result_valid,
    input  logic             result_ready,
    input  mss_pkg::status_t status,
    output mss_pkg::cmd_t    cmd
);

    mss_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mss_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            mss_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = mss_pkg::ST_EXEC;
                end
            end
            mss_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.emit ? mss_pkg::ST_LOAD : mss_pkg::ST_IDLE;
            end
            mss_pkg::ST_LOAD:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = mss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mss_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign item_ready   = (state_reg == mss_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;

    `MSS_ASSERT(a_accept_exec, clk, rst_n, (item_valid && item_ready) |=> (state_reg == mss_pkg::ST_EXEC), "accepted transaction not executed")
    `MSS_NEVER(a_load_overwrite, clk, rst_n, cmd.load && out_valid_reg && !result_ready, "pending result overwritten")
    `MSS_ASSERT(a_quiet_exec, clk, rst_n, (state_reg == mss_pkg::ST_EXEC && !status.emit) |=> (state_reg == mss_pkg::ST_IDLE), "result staged without emit")
    `MSS_ASSERT(a_load_valid, clk, rst_n, cmd.load |=> result_valid, "loaded result not presented")

endmodule

/* design/mss_dp.sv */
// Datapath: pattern RAM, display state, tick timers and result register.
module mss_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mss_pkg::item_t                item,
    input  logic                          cfg_we,
    input  logic [mss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data,
    input  mss_pkg::cmd_t                 cmd,
    output mss_pkg::status_t              status,
    output mss_pkg::result_t              result
);

    localparam int DG = mss_pkg::DIGITS;
    localparam int IW = mss_pkg::DIG_IDX_W;
    localparam int CW = mss_pkg::CNT_W;
    localparam int WW = mss_pkg::WIN_W;
    localparam int AW = mss_pkg::MSG_IDX_W;
    localparam int MD = mss_pkg::MSG_DEPTH;

    // pattern RAM; entries without a valid bit read as blank
    logic [6:0]    mem [MD];
    logic [6:0]    rd_data_reg;
    logic          rd_valid_reg;
    logic [MD-1:0] valid_reg, valid_next;

    mss_pkg::item_t   item_reg;
    mss_pkg::result_t out_reg;

    logic [7:0]    refresh_ticks_reg, refresh_ticks_next;
    logic [15:0]   bright_ticks_reg, bright_ticks_next;
    logic [7:0]    refresh_cnt_reg, refresh_cnt_next;
    logic [15:0]   dim_cnt_reg, dim_cnt_next;
    logic [IW-1:0] focus_reg, focus_next;
    logic [CW-1:0] length_reg, length_next;
    logic [CW-1:0] wp_reg, wp_next;
    logic [CW-1:0] offset_reg, offset_next;

    logic [1:0]    mode_reg [DG];
    logic [1:0]    mode_next [DG];
    logic          point_reg [DG];
    logic          point_next [DG];
    logic [15:0]   period_reg [DG];
    logic [15:0]   period_next [DG];
    logic [15:0]   count_reg [DG];
    logic [15:0]   count_next [DG];
    logic          phase_reg [DG];
    logic          phase_next [DG];

    // staged result of a tick
    logic          res_show_reg, res_show_next;
    logic          res_dp_reg, res_dp_next;
    logic          res_win_reg, res_win_next;
    logic [IW-1:0] res_sel_reg, res_sel_next;

    logic          is_tick;
    logic [IW-1:0] sel_idx;
    logic          digit_ok;
    logic [7:0]    rc_dec;
    logic [15:0]   dc_dec;
    logic [15:0]   cnt_dec;
    logic          phase_new;
    logic          show;
    logic [WW-1:0] win_idx;
    logic          win_ok;
    logic [CW-1:0] len_sat;
    logic [CW-1:0] wr_end;
    logic          wr_ok;
    logic          mem_we;
    logic          do_clear;

    assign is_tick  = (item_reg.req_type == mss_pkg::REQ_TICK);
    assign sel_idx  = is_tick ? focus_reg : item_reg.digit[IW-1:0];
    assign digit_ok = (item_reg.digit <= 2'(DG - 1));
    assign rc_dec   = refresh_cnt_reg - 8'd1;
    assign dc_dec   = dim_cnt_reg - 16'd1;
    assign cnt_dec  = count_reg[sel_idx] - 16'd1;
    assign win_idx  = WW'(focus_reg) + WW'(offset_reg);
    assign win_ok   = (win_idx < WW'(MD));
    assign len_sat  = (item_reg.value > 8'(MD)) ? CW'(MD) : item_reg.value[CW-1:0];
    assign wr_end   = (length_reg < CW'(DG)) ? CW'(DG) : length_reg;
    assign wr_ok    = (wp_reg < wr_end) && (wp_reg < CW'(MD));
    assign mem_we   = cmd.exec && (item_reg.req_type == mss_pkg::REQ_CHAR) && wr_ok;

    assign status.emit = cmd.exec && is_tick && ((rc_dec == 8'd0) || (dc_dec == 16'd0));

    always_comb
    begin
        refresh_ticks_next = refresh_ticks_reg;
        bright_ticks_next  = bright_ticks_reg;
        refresh_cnt_next   = refresh_cnt_reg;
        dim_cnt_next       = dim_cnt_reg;
        focus_next         = focus_reg;
        length_next        = length_reg;
        wp_next            = wp_reg;
        offset_next        = offset_reg;
        valid_next         = valid_reg;
        mode_next          = mode_reg;
        point_next         = point_reg;
        period_next        = period_reg;
        count_next         = count_reg;
        phase_next         = phase_reg;
        res_show_next      = res_show_reg;
        res_dp_next        = res_dp_reg;
        res_win_next       = res_win_reg;
        res_sel_next       = res_sel_reg;
        phase_new          = phase_reg[sel_idx];
        show               = 1'b0;
        do_clear           = 1'b0;

        if (cfg_we)
        begin
            if (cfg_index == mss_pkg::CFG_REFRESH)
            begin
                refresh_ticks_next = cfg_data[7:0];
            end
            else if (cfg_index == mss_pkg::CFG_BRIGHT)
            begin
                bright_ticks_next = cfg_data;
            end
        end

        if (cmd.exec)
        begin
            unique case (item_reg.req_type)
                mss_pkg::REQ_TICK:
                begin
                    if (rc_dec == 8'd0)
                    begin
                        if (mode_reg[sel_idx] == mss_pkg::MODE_BLINK)
                        begin
                            if (cnt_dec == 16'd0)
                            begin
                                phase_new           = !phase_reg[sel_idx];
                                count_next[sel_idx] = period_reg[sel_idx];
                            end
                            else
                            begin
                                count_next[sel_idx] = cnt_dec;
                            end
                            phase_next[sel_idx] = phase_new;
                            show                = phase_new;
                        end
                        else
                        begin
                            show = (mode_reg[sel_idx] == mss_pkg::MODE_ON);
                        end
                        res_show_next    = show;
                        res_dp_next      = show && point_reg[sel_idx];
                        res_win_next     = win_ok;
                        res_sel_next     = focus_reg;
                        focus_next       = (focus_reg == IW'(DG - 1)) ? '0 : focus_reg + 1'b1;
                        refresh_cnt_next = refresh_ticks_reg;
                        dim_cnt_next     = bright_ticks_reg;
                    end
                    else
                    begin
                        refresh_cnt_next = rc_dec;
                        res_show_next    = 1'b0;
                        res_dp_next      = 1'b0;
                        res_win_next     = 1'b0;
                        res_sel_next     = focus_reg;
                        dim_cnt_next     = (dc_dec == 16'd0) ? bright_ticks_reg : dc_dec;
                    end
                end
                mss_pkg::REQ_START:
                begin
                    length_next = len_sat;
                    if (len_sat < CW'(DG))
                    begin
                        wp_next  = CW'(DG) - len_sat;
                        do_clear = 1'b1;
                    end
                    else
                    begin
                        wp_next = '0;
                    end
                end
                mss_pkg::REQ_CHAR:
                begin
                    if (wr_ok)
                    begin
                        valid_next[wp_reg[AW-1:0]] = 1'b1;
                        wp_next                    = wp_reg + 1'b1;
                    end
                end
                mss_pkg::REQ_RIGHT:
                begin
                    if ((WW'(offset_reg) + WW'(DG)) < WW'(length_reg))
                    begin
                        offset_next = offset_reg + 1'b1;
                    end
                end
                mss_pkg::REQ_LEFT:
                begin
                    if (offset_reg != '0)
                    begin
                        offset_next = offset_reg - 1'b1;
                    end
                end
                mss_pkg::REQ_CLEAR:
                begin
                    do_clear = 1'b1;
                end
                mss_pkg::REQ_ON:
                begin
                    if (digit_ok)
                    begin
                        mode_next[sel_idx] = mss_pkg::MODE_ON;
                    end
                end
                mss_pkg::REQ_OFF:
                begin
                    if (digit_ok)
                    begin
                        mode_next[sel_idx] = mss_pkg::MODE_OFF;
                    end
                end
                mss_pkg::REQ_TOGGLE:
                begin
                    if (digit_ok && mode_reg[sel_idx] < mss_pkg::MODE_BLINK)
                    begin
                        mode_next[sel_idx] = mode_reg[sel_idx] ^ 2'd1;
                    end
                end
                mss_pkg::REQ_BLINK:
                begin
                    if (digit_ok)
                    begin
                        mode_next[sel_idx]   = mss_pkg::MODE_BLINK;
                        period_next[sel_idx] = item_reg.blink_reload;
                        count_next[sel_idx]  = item_reg.blink_reload;
                    end
                end
                mss_pkg::REQ_DP:
                begin
                    if (digit_ok)
                    begin
                        point_next[sel_idx] = item_reg.point_on;
                    end
                end
                default:
                begin
                end
            endcase

            // clear: blank store, all digits on, points off
            if (do_clear)
            begin
                valid_next = '0;
                for (int i = 0; i < DG; i++)
                begin
                    mode_next[i]  = mss_pkg::MODE_ON;
                    point_next[i] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refresh_ticks_reg <= mss_pkg::REFRESH_RESET;
            bright_ticks_reg  <= mss_pkg::BRIGHT_RESET;
            refresh_cnt_reg   <= mss_pkg::REFRESH_RESET;
            dim_cnt_reg       <= mss_pkg::BRIGHT_RESET;
            focus_reg         <= '0;
            length_reg        <= '0;
            wp_reg            <= '0;
            offset_reg        <= '0;
            valid_reg         <= '0;
            for (int i = 0; i < DG; i++)
            begin
                mode_reg[i]   <= mss_pkg::MODE_ON;
                point_reg[i]  <= 1'b0;
                period_reg[i] <= 16'd1;
                count_reg[i]  <= 16'd1;
                phase_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            refresh_ticks_reg <= refresh_ticks_next;
            bright_ticks_reg  <= bright_ticks_next;
            refresh_cnt_reg   <= refresh_cnt_next;
            dim_cnt_reg       <= dim_cnt_next;
            focus_reg         <= focus_next;
            length_reg        <= length_next;
            wp_reg            <= wp_next;
            offset_reg        <= offset_next;
            valid_reg         <= valid_next;
            mode_reg          <= mode_next;
            point_reg         <= point_next;
            period_reg        <= period_next;
            count_reg         <= count_next;
            phase_reg         <= phase_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= item;
        end
        res_show_reg <= res_show_next;
        res_dp_reg   <= res_dp_next;
        res_win_reg  <= res_win_next;
        res_sel_reg  <= res_sel_next;
        if (cmd.load)
        begin
            out_reg.segments <= (res_show_reg && res_win_reg && rd_valid_reg) ?
                                rd_data_reg : 7'h00;
            out_reg.point    <= res_dp_reg;
            out_reg.select   <= 2'(res_sel_reg);
        end
    end

    // RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg[AW-1:0]] <= mss_pkg::decode_glyph(item_reg.value);
        end
        if (cmd.exec && is_tick)
        begin
            rd_data_reg  <= mem[win_idx[AW-1:0]];
            rd_valid_reg <= valid_reg[win_idx[AW-1:0]];
        end
    end

    assign result = out_reg;

endmodule

/* design/multiplexed_seven_segment_scanner_top.sv */
// Top level of the multiplexed seven-segment display scanner.
// Drives a DIGITS-digit multiplexed seven-segment display one digit at a
// time. Each item transaction is a tick or a command: start message, message
// character (decoded to a glyph and written to a MSG_DEPTH-entry pattern
// RAM), scroll right/left, clear, per-digit on/off/toggle/blink and decimal
// point. A tick counts refresh_ticks down to a refresh of the focused digit,
// which yields one result transaction (segments, point, select) and moves
// focus on; between refreshes, bright_ticks counting down yields a blank
// result for dimming. Other items give no result. A command passes through
// accept and execute states, a tick with a result also a load state, since
// the pattern RAM read is registered between execute and result load. A
// result waits in the output register while the next item is accepted; only
// when a second result is ready before the first is taken does the scanner
// stall. Clearing the store is done by resetting the per-entry valid
// bits, so there is no clearing pass after reset. Configuration writes
// (index 0 refresh_ticks, index 1 bright_ticks, others ignored) are always
// accepted and are meant to be issued while the scanner is idle.
module multiplexed_seven_segment_scanner_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  mss_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output mss_pkg::result_t              result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);

    mss_pkg::cmd_t    cmd;
    mss_pkg::status_t status;

    // config register writes are always accepted
    assign cfg_ready = 1'b1;

    mss_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    mss_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule
